/* rtl/gcode_line_word_parser_unit_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef GCODE_LINE_WORD_PARSER_UNIT_DEFINES_SVH
`define GCODE_LINE_WORD_PARSER_UNIT_DEFINES_SVH

// The condition must never hold while out of reset.
`define GCLP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define GCLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define GCLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gclp_pkg.sv */
package gclp_pkg;

  // Number of fraction digits kept for the axis words.
  localparam int FRAC_DIGITS = 3;
  localparam int CNT_W       = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int SCALE_W     = $clog2((10 ** FRAC_DIGITS) + 1);

  localparam int ACC_W   = 33;
  localparam int PROD_W  = ACC_W + SCALE_W;
  localparam logic [ACC_W-1:0] ACC_CAP = 33'h1_0000_0000;
  localparam logic [31:0]      POS_MAX = 32'h7FFF_FFFF;

  localparam int TQ_DEPTH = 4;
  localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
  localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [2:0] {
    TK_OTHER, TK_DIGIT, TK_DOT, TK_PLUS, TK_MINUS, TK_SPACE, TK_LETTER, TK_NUL
  } tok_kind_e;

  typedef enum logic [2:0] {
    LET_NONE, LET_G, LET_M, LET_X, LET_Y, LET_Z, LET_F
  } letter_e;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_LEAD, MODE_SIGNED, MODE_INT, MODE_FRAC
  } mode_e;

  typedef enum logic [2:0] {
    CMD_UNKNOWN, CMD_G0, CMD_G1, CMD_M3, CMD_M5
  } cmd_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic [2:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        feed;
    logic               has_x;
    logic               has_y;
    logic               has_z;
    logic               has_feed;
  } res_item_t;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    letter_e    letter;
    logic       last;
  } token_t;

  // Accumulator times ten plus a digit, saturated at 2^32.
  function automatic logic [ACC_W-1:0] times_ten_add(logic [ACC_W-1:0] acc,
                                                     logic [3:0] dig);
    logic [ACC_W+3:0] r;
    r = {acc, 3'b000} + {2'b00, acc, 1'b0} + (ACC_W + 4)'(dig);
    if (r > (ACC_W + 4)'(ACC_CAP)) begin
      return ACC_CAP;
    end
    return r[ACC_W-1:0];
  endfunction

  // Ten to the power of the fraction digits still missing.
  function automatic logic [SCALE_W-1:0] pow10_scale(logic [CNT_W-1:0] cnt);
    logic [SCALE_W-1:0] s;
    s = SCALE_W'(1);
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (CNT_W'(k) >= cnt) begin
        s = SCALE_W'(s * 4'd10);
      end
    end
    return s;
  endfunction

  // Fixed-point value of a finished decimal, magnitude saturated.
  function automatic logic [31:0] fixed_value(logic [ACC_W-1:0] acc,
                                              logic [CNT_W-1:0] cnt,
                                              logic neg);
    logic [PROD_W-1:0] m;
    logic [31:0]       mag;
    m = PROD_W'(acc) * PROD_W'(pow10_scale(cnt));
    if (m > PROD_W'(POS_MAX)) begin
      mag = POS_MAX;
    end else begin
      mag = m[31:0];
    end
    return neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

/* rtl/gcode_line_word_parser_unit.sv */
// Channel   Handshake          Payload     Moves
// input     push_i / full_o    item_i      one character of a command line
// result    pop_i / empty_o    res_o       one parsed frame per finished line
//
// An item is taken each cycle while the back end keeps up. An item with a
// nonzero character and line_end set makes the back end hold off the next token
// while it emits the frame (a zero byte emits in its own cycle); the four-entry
// token queue hides short bursts.
// A full two-entry result queue at a line end stalls the back end, and the token
// queue then fills until full_o rises. Reset empties both queues and the scanner.
`include "gcode_line_word_parser_unit_defines.svh"

module gcode_line_word_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  gclp_pkg::in_item_t  item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output gclp_pkg::res_item_t res_o
);

  // Classified characters between the front and the back.
  logic                tok_valid;
  gclp_pkg::token_t    tok;
  logic                tok_pop;

  // Frames between the back and the result queue.
  logic                res_push;
  gclp_pkg::res_item_t res_frame;
  logic                out_space;
  logic                end_pend;

  // Events watched by the checks below.
  logic                push_lost;
  logic                last_taken;
  logic                push_done;

  // The front classifies each character (digit, sign, point, blank, word
  // letter, line terminator) and queues it as a small token.
  gclp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (item_i),
    .full_o      (full_o),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // The back runs the word scanner: it accumulates digits with a
  // times-ten add, folds finished words into the frame, and at line end
  // hands the frame to the result queue and clears its state.
  gclp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .out_space_i (out_space),
    .res_push_o  (res_push),
    .res_o       (res_frame),
    .end_pend_o  (end_pend)
  );

  // Results wait here until popped.
  gclp_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res_frame),
    .out_space_o (out_space),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res_o)
  );

  assign push_lost  = res_push && !out_space;
  assign last_taken = tok_pop && tok.last && (tok.kind != gclp_pkg::TK_NUL);
  assign push_done  = res_push && out_space;

  // A frame is never handed over while the result queue is full.
  `GCLP_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_lost, "frame lost on full queue")

  // While the last word of a line is still being folded, no token is taken.
  `GCLP_ASSERT_IMPL(a_hold_during_end, clk_i, rst_ni, end_pend, !tok_pop, "token taken at end")

  // A last character that is not a zero byte leaves the line end pending.
  `GCLP_ASSERT_NEXT(a_end_follows_last, clk_i, rst_ni, last_taken, end_pend, "end not pending")

  // A frame handed over is visible on the result side next cycle.
  `GCLP_ASSERT_NEXT(a_push_shows, clk_i, rst_ni, push_done, !empty_o, "pushed frame not visible")

endmodule

/* rtl/gclp_front.sv */
module gclp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gclp_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              tok_valid_o,
  output gclp_pkg::token_t  tok_o,
  input  logic              tok_pop_i
);

  gclp_pkg::token_t               tok_new;
  logic [7:0]                     upper;
  logic [7:0]                     dig_ofs;
  gclp_pkg::token_t               tq_q [gclp_pkg::TQ_DEPTH];
  logic [gclp_pkg::TQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [gclp_pkg::TQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [gclp_pkg::TQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           wr_en;
  logic                           rd_en;

  // Classify the incoming character.
  always_comb begin
    upper   = ((item_i.ch >= gclp_pkg::CH_LOW_A) && (item_i.ch <= gclp_pkg::CH_LOW_Z)) ?
              (item_i.ch - gclp_pkg::CASE_OFS) : item_i.ch;
    dig_ofs = item_i.ch - gclp_pkg::CH_ZERO;
    tok_new.kind   = gclp_pkg::TK_OTHER;
    tok_new.digit  = dig_ofs[3:0];
    tok_new.letter = gclp_pkg::LET_NONE;
    tok_new.last   = item_i.line_end;
    if (item_i.ch == gclp_pkg::CH_NUL) begin
      tok_new.kind = gclp_pkg::TK_NUL;
    end else if ((item_i.ch >= gclp_pkg::CH_ZERO) && (item_i.ch <= gclp_pkg::CH_NINE)) begin
      tok_new.kind = gclp_pkg::TK_DIGIT;
    end else if (item_i.ch == gclp_pkg::CH_DOT) begin
      tok_new.kind = gclp_pkg::TK_DOT;
    end else if (item_i.ch == gclp_pkg::CH_PLUS) begin
      tok_new.kind = gclp_pkg::TK_PLUS;
    end else if (item_i.ch == gclp_pkg::CH_MINUS) begin
      tok_new.kind = gclp_pkg::TK_MINUS;
    end else if ((item_i.ch == gclp_pkg::CH_SPACE) ||
                 ((item_i.ch >= gclp_pkg::CH_TAB) && (item_i.ch <= gclp_pkg::CH_CR))) begin
      tok_new.kind = gclp_pkg::TK_SPACE;
    end else begin
      unique case (upper)
        gclp_pkg::CH_G: tok_new.letter = gclp_pkg::LET_G;
        gclp_pkg::CH_M: tok_new.letter = gclp_pkg::LET_M;
        gclp_pkg::CH_X: tok_new.letter = gclp_pkg::LET_X;
        gclp_pkg::CH_Y: tok_new.letter = gclp_pkg::LET_Y;
        gclp_pkg::CH_Z: tok_new.letter = gclp_pkg::LET_Z;
        gclp_pkg::CH_F: tok_new.letter = gclp_pkg::LET_F;
        default:        tok_new.letter = gclp_pkg::LET_NONE;
      endcase
      if (tok_new.letter != gclp_pkg::LET_NONE) begin
        tok_new.kind = gclp_pkg::TK_LETTER;
      end
    end
  end

  assign full_o      = (cnt_q == gclp_pkg::TQ_CNT_W'(gclp_pkg::TQ_DEPTH));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = tq_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? (wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = rd_en ? (rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q + gclp_pkg::TQ_CNT_W'(wr_en) - gclp_pkg::TQ_CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tq_q[wr_ptr_q] <= tok_new;
    end
  end

endmodule

/* rtl/gclp_back.sv */
module gclp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  input  gclp_pkg::token_t    tok_i,
  output logic                tok_pop_o,
  input  logic                out_space_i,
  output logic                res_push_o,
  output gclp_pkg::res_item_t res_o,
  output logic                end_pend_o
);

  gclp_pkg::mode_e              mode_q, mode_d;
  gclp_pkg::letter_e            letter_q, letter_d;
  logic [gclp_pkg::ACC_W-1:0]   accum_q, accum_d;
  logic [gclp_pkg::CNT_W-1:0]   frac_cnt_q, frac_cnt_d;
  logic                         neg_q, neg_d;
  logic                         end_pend_q, end_pend_d;
  gclp_pkg::res_item_t          frame_q, frame_d, frame_f;

  logic                         tok_take;
  logic                         fed;
  logic                         end_now;
  logic                         busy;
  logic                         is_dec;
  logic                         fits;
  logic                         num_take;
  logic                         fin_en;
  logic                         start_let;
  logic [gclp_pkg::ACC_W-1:0]   acc_next;

  // Handshake and classification of what this token does.
  always_comb begin
    tok_take = !end_pend_q && tok_valid_i && ((tok_i.kind != gclp_pkg::TK_NUL) || out_space_i);
    fed      = tok_take && (tok_i.kind != gclp_pkg::TK_NUL);
    end_now  = (end_pend_q && out_space_i) || (tok_take && (tok_i.kind == gclp_pkg::TK_NUL));
    busy     = (mode_q != gclp_pkg::MODE_IDLE);
    is_dec   = letter_q inside {gclp_pkg::LET_X, gclp_pkg::LET_Y, gclp_pkg::LET_Z};
    case (tok_i.kind) inside
      gclp_pkg::TK_DIGIT:                     fits = 1'b1;
      gclp_pkg::TK_DOT:                       fits = is_dec && (mode_q != gclp_pkg::MODE_FRAC);
      gclp_pkg::TK_PLUS, gclp_pkg::TK_MINUS,
      gclp_pkg::TK_SPACE:                     fits = (mode_q == gclp_pkg::MODE_LEAD);
      default:                                fits = 1'b0;
    endcase
    num_take  = fed && busy && fits;
    fin_en    = (fed && busy && !fits) || (end_now && busy);
    start_let = fed && (!busy || !fits) && (tok_i.kind == gclp_pkg::TK_LETTER);
  end

  assign tok_pop_o  = tok_take;
  assign end_pend_o = end_pend_q;

  // Scan mode and active letter.
  always_comb begin
    mode_d   = mode_q;
    letter_d = letter_q;
    if (end_now) begin
      mode_d   = gclp_pkg::MODE_IDLE;
      letter_d = gclp_pkg::LET_NONE;
    end else if (num_take) begin
      unique case (tok_i.kind) inside
        gclp_pkg::TK_DIGIT: begin
          if (mode_q != gclp_pkg::MODE_FRAC) begin
            mode_d = gclp_pkg::MODE_INT;
          end
        end
        gclp_pkg::TK_DOT:                       mode_d = gclp_pkg::MODE_FRAC;
        gclp_pkg::TK_PLUS, gclp_pkg::TK_MINUS: mode_d = gclp_pkg::MODE_SIGNED;
        default:                                mode_d = mode_q;
      endcase
    end else if (start_let) begin
      mode_d   = gclp_pkg::MODE_LEAD;
      letter_d = tok_i.letter;
    end else if (fin_en) begin
      mode_d   = gclp_pkg::MODE_IDLE;
      letter_d = gclp_pkg::LET_NONE;
    end
  end

  // Number accumulator, sign and fraction digit count.
  always_comb begin
    acc_next   = gclp_pkg::times_ten_add(accum_q, tok_i.digit);
    accum_d    = accum_q;
    frac_cnt_d = frac_cnt_q;
    neg_d      = neg_q;
    if (end_now || fin_en || start_let) begin
      accum_d    = '0;
      frac_cnt_d = '0;
      neg_d      = 1'b0;
    end else if (num_take) begin
      case (tok_i.kind) inside
        gclp_pkg::TK_DIGIT: begin
          if (mode_q != gclp_pkg::MODE_FRAC) begin
            accum_d = acc_next;
          end else if (frac_cnt_q < gclp_pkg::CNT_W'(gclp_pkg::FRAC_DIGITS)) begin
            accum_d    = acc_next;
            frac_cnt_d = frac_cnt_q + 1'b1;
          end
        end
        gclp_pkg::TK_PLUS, gclp_pkg::TK_MINUS: neg_d = (tok_i.kind == gclp_pkg::TK_MINUS);
        default: neg_d = neg_q;
      endcase
    end
  end

  // The frame with the pending word folded in.
  always_comb begin
    frame_f = frame_q;
    if (fin_en) begin
      case (letter_q)
        gclp_pkg::LET_G: begin
          if (accum_q == '0) begin
            frame_f.command   = gclp_pkg::CMD_G0;
            frame_f.valid_res = 1'b1;
          end else if ((accum_q == gclp_pkg::ACC_W'(1)) && !neg_q) begin
            frame_f.command   = gclp_pkg::CMD_G1;
            frame_f.valid_res = 1'b1;
          end
        end
        gclp_pkg::LET_M: begin
          if ((accum_q == gclp_pkg::ACC_W'(3)) && !neg_q) begin
            frame_f.command   = gclp_pkg::CMD_M3;
            frame_f.valid_res = 1'b1;
          end else if ((accum_q == gclp_pkg::ACC_W'(5)) && !neg_q) begin
            frame_f.command   = gclp_pkg::CMD_M5;
            frame_f.valid_res = 1'b1;
          end
        end
        gclp_pkg::LET_X: begin
          frame_f.pos_x = gclp_pkg::fixed_value(accum_q, frac_cnt_q, neg_q);
          frame_f.has_x = 1'b1;
        end
        gclp_pkg::LET_Y: begin
          frame_f.pos_y = gclp_pkg::fixed_value(accum_q, frac_cnt_q, neg_q);
          frame_f.has_y = 1'b1;
        end
        gclp_pkg::LET_Z: begin
          frame_f.pos_z = gclp_pkg::fixed_value(accum_q, frac_cnt_q, neg_q);
          frame_f.has_z = 1'b1;
        end
        gclp_pkg::LET_F: begin
          if (accum_q >= gclp_pkg::ACC_CAP) begin
            frame_f.feed = '1;
          end else if (neg_q) begin
            frame_f.feed = 32'd0 - accum_q[31:0];
          end else begin
            frame_f.feed = accum_q[31:0];
          end
          frame_f.has_feed = 1'b1;
        end
        default: frame_f = frame_q;
      endcase
    end
  end

  always_comb begin
    frame_d = frame_q;
    if (end_now) begin
      frame_d = '0;
    end else if (fin_en) begin
      frame_d = frame_f;
    end
    end_pend_d = end_pend_q;
    if (fed && tok_i.last) begin
      end_pend_d = 1'b1;
    end else if (end_pend_q && out_space_i) begin
      end_pend_d = 1'b0;
    end
  end

  assign res_push_o = end_now;
  assign res_o      = frame_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= gclp_pkg::MODE_IDLE;
      letter_q   <= gclp_pkg::LET_NONE;
      accum_q    <= '0;
      frac_cnt_q <= '0;
      neg_q      <= 1'b0;
      end_pend_q <= 1'b0;
      frame_q    <= '0;
    end else begin
      mode_q     <= mode_d;
      letter_q   <= letter_d;
      accum_q    <= accum_d;
      frac_cnt_q <= frac_cnt_d;
      neg_q      <= neg_d;
      end_pend_q <= end_pend_d;
      frame_q    <= frame_d;
    end
  end

endmodule

/* rtl/gclp_out_q.sv */
module gclp_out_q (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_push_i,
  input  gclp_pkg::res_item_t res_i,
  output logic                out_space_o,
  output logic                empty_o,
  input  logic                pop_i,
  output gclp_pkg::res_item_t res_o
);

  gclp_pkg::res_item_t slot_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                wr_en;
  logic                rd_en;

  assign out_space_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign res_o       = slot_q[rd_ptr_q];
  assign wr_en       = res_push_i && out_space_o;
  assign rd_en       = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

/* tb/sv/gclp_frame_check_pkg.sv */
package gclp_frame_check_pkg;
  import gclp_pkg::*;

  // Tracks the parse of the current line and holds the frames still owed by the unit.
  class frame_scoreboard;
    mode_e       scan;
    letter_e     word;
    bit          neg;
    logic [32:0] acc;
    int unsigned frac_n;
    cmd_e        cmd;
    bit          cmd_ok;
    logic [31:0] x_val;
    logic [31:0] y_val;
    logic [31:0] z_val;
    logic [31:0] feed_val;
    bit [3:0]    seen;

    res_item_t   owed_frames[$];
    int unsigned mismatches;
    int unsigned frames_checked;
    int unsigned chars_noted;
    int unsigned cmd_hits[5];

    function new();
      clear_line();
    endfunction

    function void drop_number();
      scan   = MODE_IDLE;
      word   = LET_NONE;
      neg    = 1'b0;
      acc    = '0;
      frac_n = 0;
    endfunction

    function void clear_line();
      drop_number();
      cmd      = CMD_UNKNOWN;
      cmd_ok   = 1'b0;
      x_val    = '0;
      y_val    = '0;
      z_val    = '0;
      feed_val = '0;
      seen     = '0;
    endfunction

    // Decimal shift-in with the magnitude pinned at 2^32.
    function logic [32:0] mac10(logic [32:0] v, logic [3:0] d);
      logic [36:0] r;
      r = 37'(v) * 37'd10 + 37'(d);
      if (r > 37'(ACC_CAP)) begin
        return ACC_CAP;
      end
      return r[32:0];
    endfunction

    function logic [31:0] scaled();
      logic [32:0] m;
      m = acc;
      for (int k = frac_n; k < FRAC_DIGITS; k++) begin
        m = mac10(m, 4'd0);
      end
      if (m > 33'(POS_MAX)) begin
        m = 33'(POS_MAX);
      end
      return neg ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

    function void close_word();
      case (word)
        LET_G: begin
          if (acc == 0) begin
            cmd = CMD_G0;
            cmd_ok = 1'b1;
          end else if (acc == 1 && !neg) begin
            cmd = CMD_G1;
            cmd_ok = 1'b1;
          end
        end
        LET_M: begin
          if (acc == 3 && !neg) begin
            cmd = CMD_M3;
            cmd_ok = 1'b1;
          end else if (acc == 5 && !neg) begin
            cmd = CMD_M5;
            cmd_ok = 1'b1;
          end
        end
        LET_X: begin
          x_val = scaled();
          seen[0] = 1'b1;
        end
        LET_Y: begin
          y_val = scaled();
          seen[1] = 1'b1;
        end
        LET_Z: begin
          z_val = scaled();
          seen[2] = 1'b1;
        end
        LET_F: begin
          if (acc >= ACC_CAP) begin
            feed_val = '1;
          end else if (neg) begin
            feed_val = 32'd0 - acc[31:0];
          end else begin
            feed_val = acc[31:0];
          end
          seen[3] = 1'b1;
        end
        default: ;
      endcase
      drop_number();
    endfunction

    // Returns 1 when the character belongs to the number being read.
    function bit absorb(logic [7:0] c);
      bit axis;
      axis = word inside {LET_X, LET_Y, LET_Z};
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (scan == MODE_FRAC) begin
          if (frac_n < FRAC_DIGITS) begin
            acc = mac10(acc, 4'(c - CH_ZERO));
            frac_n++;
          end
        end else begin
          acc = mac10(acc, 4'(c - CH_ZERO));
          scan = MODE_INT;
        end
        return 1'b1;
      end
      if (c == CH_DOT && axis && scan != MODE_FRAC) begin
        scan = MODE_FRAC;
        return 1'b1;
      end
      if ((c == CH_PLUS || c == CH_MINUS) && scan == MODE_LEAD) begin
        neg = (c == CH_MINUS);
        scan = MODE_SIGNED;
        return 1'b1;
      end
      if ((c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) && scan == MODE_LEAD) begin
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_char(logic [7:0] c);
      logic [7:0] u;
      if (scan != MODE_IDLE) begin
        if (absorb(c)) begin
          return;
        end
        close_word();
      end
      u = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
      case (u)
        CH_G: word = LET_G;
        CH_M: word = LET_M;
        CH_X: word = LET_X;
        CH_Y: word = LET_Y;
        CH_Z: word = LET_Z;
        CH_F: word = LET_F;
        default: return;
      endcase
      scan   = MODE_LEAD;
      neg    = 1'b0;
      acc    = '0;
      frac_n = 0;
    endfunction

    function void note_char(in_item_t it);
      res_item_t f;
      chars_noted++;
      if (it.ch != CH_NUL) begin
        take_char(it.ch);
      end
      if (it.ch != CH_NUL && !it.line_end) begin
        return;
      end
      if (scan != MODE_IDLE) begin
        close_word();
      end
      f.valid_res = cmd_ok;
      f.command   = cmd;
      f.pos_x     = x_val;
      f.pos_y     = y_val;
      f.pos_z     = z_val;
      f.feed      = feed_val;
      f.has_x     = seen[0];
      f.has_y     = seen[1];
      f.has_z     = seen[2];
      f.has_feed  = seen[3];
      owed_frames.push_back(f);
      clear_line();
    endfunction

    function int outstanding();
      return owed_frames.size();
    endfunction

    function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("frame %0d, %s: expected 0x%08h, got 0x%08h",
                   frames_checked, name, want, got);
        end
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_frame(res_item_t got);
      res_item_t want;
      bit        bad;
      if (owed_frames.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected frame with no line finished: %p", got);
        end
        mismatches++;
        return;
      end
      want = owed_frames.pop_front();
      bad = 1'b0;
      bad |= field_differs("valid_res", 32'(want.valid_res), 32'(got.valid_res));
      bad |= field_differs("command", 32'(want.command), 32'(got.command));
      bad |= field_differs("pos_x", want.pos_x, got.pos_x);
      bad |= field_differs("pos_y", want.pos_y, got.pos_y);
      bad |= field_differs("pos_z", want.pos_z, got.pos_z);
      bad |= field_differs("feed", want.feed, got.feed);
      bad |= field_differs("has_x", 32'(want.has_x), 32'(got.has_x));
      bad |= field_differs("has_y", 32'(want.has_y), 32'(got.has_y));
      bad |= field_differs("has_z", 32'(want.has_z), 32'(got.has_z));
      bad |= field_differs("has_feed", 32'(want.has_feed), 32'(got.has_feed));
      if (bad) begin
        mismatches++;
      end
      if (want.command <= 3'd4) begin
        cmd_hits[want.command]++;
      end
      frames_checked++;
    endfunction
  endclass

endpackage

/* tb/sv/gcode_line_word_parser_unit_test.sv */
module gcode_line_word_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gclp_pkg::*;
  import gclp_frame_check_pkg::*;

  // Rough stimulus size and run shaping.
  localparam int ITEM_TARGET    = 1150;
  localparam int TAIL_ITEMS     = 150;     // final stretch driven with no idling
  localparam int HOLDOFF_AT     = 300;     // item count at which results are held back
  localparam int HOLDOFF_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 16;
  // The limit sits far above the slowest correct run: every item behind the
  // longest sender gap, every frame behind the longest receiver stall, plus the hold-off.
  localparam int CYCLE_LIMIT    = 200000;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push_i = 1'b0;
  logic      pop_i  = 1'b0;
  in_item_t  item_i = '0;
  logic      full_o;
  logic      empty_o;
  res_item_t res_o;

  frame_scoreboard sb;
  in_item_t        char_stream[$];
  int              sent_count  = 0;
  int              tail_start  = 0;
  int              full_stalls = 0;
  int              lines_built = 0;
  int              cycle_count = 0;

  gcode_line_word_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .full_o (full_o),
    .item_i (item_i),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .res_o  (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus building. Lines are assembled as a flat list of characters up
  // front; the sender then walks the list.
  // ---------------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c, bit last);
    in_item_t it;
    it.ch       = c;
    it.line_end = last;
    char_stream.push_back(it);
  endfunction

  // A string of characters, with line_end set on the last one when asked.
  function automatic void put_text(string s, bit end_on_last);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i], end_on_last && (i == s.len() - 1));
    end
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Space, or one of the control characters from tab through carriage return.
  function automatic logic [7:0] any_blank();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  // One word: a letter (mostly a known one, in either case), optional blanks
  // and sign, then a number whose size ranges from nothing to long enough to
  // saturate the accumulator. Axis words may carry a fraction of up to five digits.
  function automatic void put_word();
    logic [7:0] letter;
    int         pick;
    int         n_digits;
    int         n_blanks;
    bit         axis;
    pick = $urandom_range(0, 7);
    case (pick)
      0: letter = CH_G;
      1: letter = CH_M;
      2: letter = CH_X;
      3: letter = CH_Y;
      4: letter = CH_Z;
      5: letter = CH_F;
      // Any capital letter; most of them are not words the unit knows.
      default: letter = 8'h41 + 8'($urandom_range(0, 25));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      letter = letter + CASE_OFS;
    end
    put_char(letter, 1'b0);
    axis = pick inside {2, 3, 4};

    n_blanks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n_blanks) put_char(any_blank(), 1'b0);

    case ($urandom_range(0, 5))
      0: put_char(CH_MINUS, 1'b0);
      1: put_char(CH_PLUS, 1'b0);
      default: ;
    endcase

    if (pick <= 1 && $urandom_range(0, 3) != 0) begin
      // G and M words mostly carry one of the codes that select a command.
      case ($urandom_range(0, 3))
        0: put_char(CH_ZERO, 1'b0);
        1: put_char(CH_ZERO + 8'd1, 1'b0);
        2: put_char(CH_ZERO + 8'd3, 1'b0);
        default: put_char(CH_ZERO + 8'd5, 1'b0);
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0: n_digits = 0;
        1: n_digits = $urandom_range(9, 12);
        default: n_digits = $urandom_range(1, 4);
      endcase
      repeat (n_digits) put_char(any_digit(), 1'b0);
      if (axis && $urandom_range(0, 1) == 1) begin
        put_char(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 5)) put_char(any_digit(), 1'b0);
      end
    end

    // Now and then an exponent marker, which must end the number.
    if ($urandom_range(0, 15) == 0) begin
      put_char(($urandom_range(0, 1) == 1) ? 8'h65 : 8'h45, 1'b0);
    end
  endfunction

  // Mostly well-formed lines of up to five words; one line in ten is raw
  // bytes, line_end set at random, ended by a zero byte.
  function automatic void put_line();
    int start;
    int n_words;
    start = char_stream.size();
    lines_built++;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) put_char(8'($urandom), $urandom_range(0, 7) == 0);
      put_char(CH_NUL, $urandom_range(0, 1) == 1);
      return;
    end
    n_words = $urandom_range(0, 5);
    repeat (n_words) begin
      put_word();
      if ($urandom_range(0, 1) == 1) begin
        put_char(any_blank(), 1'b0);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      put_char(CH_NUL, 1'b0);
    end else if (char_stream.size() == start) begin
      put_char(CH_SPACE, 1'b1);
    end else begin
      char_stream[char_stream.size() - 1].line_end = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. An item is driven at a rising edge and held until an edge at
  // which full_o was low; full_o is sampled as it stood before that edge.
  // ---------------------------------------------------------------------------

  task automatic send_char(in_item_t it);
    push_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full_o) begin
      full_stalls++;
      @(posedge clk_i);
    end
    sb.note_char(it);
  endtask

  // ---------------------------------------------------------------------------
  // Result side. pop_i is re-decided each cycle. Stall bursts come at random,
  // except in the final stretch. Once, after HOLDOFF_AT items, pop is held
  // low long enough for the result and token queues to fill so that full_o
  // has to push back on the sender.
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    bit holdoff_done;
    stall_left   = 0;
    holdoff_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        sb.check_frame(res_o);
      end
      if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        stall_left   = HOLDOFF_CYCLES;
      end else if (stall_left == 0 && sent_count < tail_start
                   && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d frames still owed.",
             cycle_count, sb.outstanding());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    sb = new();

    // Directed lines. The first one has a newline between G and its number,
    // a negative zero code, more fraction digits than are kept and an exponent
    // marker, and is ended by a zero byte. The second is lower case, selects
    // M5, feeds a negative F that wraps and ends on a bare Y with line_end.
    // The third selects G1, carries a 0xFF byte that must be ignored and ends
    // on a bare M that selects nothing.
    put_text("G\n-0X1.23456e", 1'b0);
    put_char(CH_NUL, 1'b0);
    put_text("m5F-7y", 1'b1);
    put_text("g1", 1'b0);
    put_char(8'hFF, 1'b0);
    put_text("M", 1'b1);
    lines_built = 3;

    while (char_stream.size() < ITEM_TARGET) begin
      put_line();
    end
    tail_start = char_stream.size() - TAIL_ITEMS;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The sender pauses in bursts at random, never in the tail.
    foreach (char_stream[i]) begin
      send_char(char_stream[i]);
      sent_count = i + 1;
      if (sent_count < tail_start && $urandom_range(0, 7) == 0) begin
        push_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    push_i <= 1'b0;

    // Wait for every owed frame, then a little longer to catch stray ones.
    while (sb.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d characters in %0d lines; checked %0d frames (G0 %0d, G1 %0d, M3 %0d, M5 %0d, none %0d).",
             sb.chars_noted, lines_built, sb.frames_checked, sb.cmd_hits[CMD_G0],
             sb.cmd_hits[CMD_G1], sb.cmd_hits[CMD_M3], sb.cmd_hits[CMD_M5],
             sb.cmd_hits[CMD_UNKNOWN]);
    $display("Input pushed back by a full unit for %0d cycles; %0d mismatching frames.",
             full_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/gclp_pkg.sv
rtl/gclp_front.sv
rtl/gclp_back.sv
rtl/gclp_out_q.sv
rtl/gcode_line_word_parser_unit.sv
tb/sv/gclp_frame_check_pkg.sv
tb/sv/gcode_line_word_parser_unit_test.sv
